// ===== rtl/skt_pkg.sv =====
// Shared types and codes for the sorted key table.
// No dependencies; imported by skt_cell and sorted_key_table.
`timescale 1ns / 1ps

package skt_pkg;

    localparam int KEY_W  = 32;
    localparam int NAME_W = 64;

    typedef enum logic [1:0] {
        REQ_INSERT    = 2'd0,
        REQ_DELETE    = 2'd1,
        REQ_LIST_ASC  = 2'd2,
        REQ_LIST_DESC = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_DELETED   = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_LIST      = 3'd5,
        ST_EMPTY     = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROT_LEFT,
        CELL_ROT_RIGHT
    } t_cell_op;

    typedef struct packed {
        logic     cmp;
        t_cell_op op;
    } t_cell_ctl;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [NAME_W-1:0]       name;
    } t_entry;

endpackage

// ===== rtl/skt_cell.sv =====
// One slot of the sorted chain: holds an entry and its compare flags.
// Depends on skt_pkg.
`timescale 1ns / 1ps

module skt_cell (
    input  logic                           i_clk,
    input  skt_pkg::t_cell_ctl             i_ctl,
    input  logic signed [skt_pkg::KEY_W-1:0] i_cmp_key,
    input  skt_pkg::t_entry                i_new,
    input  skt_pkg::t_entry                i_left,
    input  logic                           i_left_ge,
    input  skt_pkg::t_entry                i_right,
    input  logic                           i_right_valid,
    input  skt_pkg::t_entry                i_head,
    input  logic                           i_valid,
    output skt_pkg::t_entry                o_entry,
    output logic                           o_ge,
    output logic                           o_hit
);
    import skt_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    logic   r_gt;
    logic   r_eq;

    assign o_entry = r_entry;
    assign o_ge    = !i_valid || r_gt;
    assign o_hit   = i_valid && r_eq;

    always_comb begin
        n_entry = r_entry;
        case (i_ctl.op)
            CELL_INSERT: begin
                // shift right from the insert point, take the new entry there
                if (o_ge) begin
                    n_entry = i_left_ge ? i_left : i_new;
                end
            end
            CELL_DELETE: begin
                if (i_valid && (r_gt || r_eq)) begin
                    n_entry = i_right;
                end
            end
            CELL_ROT_LEFT: begin
                if (i_valid) begin
                    n_entry = i_right_valid ? i_right : i_head;
                end
            end
            CELL_ROT_RIGHT: begin
                if (i_valid) begin
                    n_entry = i_left;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (i_ctl.cmp) begin
            r_gt <= r_entry.key > i_cmp_key;
            r_eq <= r_entry.key == i_cmp_key;
        end
    end

endmodule

// ===== rtl/sorted_key_table.sv =====
// Sorted key table: a chain of CAPACITY cells kept in ascending signed key order.
// Insert and delete compare the key on acceptance, then shift and register the result
// once the output slot is free; the next request is taken back in idle while it drains.
// A list emits the head (ascending) or tail (descending) and rotates the chain, one
// entry per cycle while results are taken; an empty table answers with an empty status.
// Synchronous active-low reset clears the count and handshake; cells keep contents.
`timescale 1ns / 1ps

module sorted_key_table #(
    parameter int CAPACITY = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [1:0]                       i_req_type,
    input  logic signed [skt_pkg::KEY_W-1:0] i_key,
    input  logic [skt_pkg::NAME_W-1:0]       i_name_code,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [2:0]                       o_status,
    output logic signed [skt_pkg::KEY_W-1:0] o_out_key,
    output logic [skt_pkg::NAME_W-1:0]       o_out_name,
    output logic                             o_last
);
    import skt_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LIST
    } t_state;

    t_state            r_state;
    t_req              r_req;
    logic signed [KEY_W-1:0] r_key;
    logic [NAME_W-1:0] r_name;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_idx;

    logic              r_o_valid;
    t_status           r_o_status;
    logic signed [KEY_W-1:0] r_o_key;
    logic [NAME_W-1:0] r_o_name;
    logic              r_o_last;

    t_cell_ctl         w_ctl;
    t_entry            w_new;
    t_entry            w_entry [CAPACITY];
    logic [CAPACITY-1:0] w_valid;
    logic [CAPACITY-1:0] w_ge;
    logic [CAPACITY-1:0] w_hit;
    t_entry            w_tail;
    logic              w_free;
    logic              w_found;
    logic              w_full;
    logic              w_accept;
    logic              w_list_last;

    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign o_valid    = r_o_valid;
    assign o_status   = r_o_status;
    assign o_out_key  = r_o_key;
    assign o_out_name = r_o_name;
    assign o_last     = r_o_last;

    // the output slot can take a new result this cycle
    assign w_free      = !r_o_valid || i_ready;
    assign w_found     = |w_hit;
    assign w_full      = (r_count == CW'(CAPACITY));
    assign w_list_last = (r_idx == r_count - CW'(1));
    assign w_new       = '{key: r_key, name: r_name};

    // occupancy follows from the count: cells below it hold entries
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_valid[i] = CW'(i) < r_count;
        end
    end

    // pick the highest occupied cell; at most one cell qualifies
    always_comb begin
        w_tail = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_valid[i] && (i == CAPACITY - 1 || !w_valid[(i + 1) % CAPACITY])) begin
                w_tail = w_tail | w_entry[i];
            end
        end
    end

    // chain control: compare on acceptance, then shift or rotate
    always_comb begin
        w_ctl.cmp = w_accept;
        w_ctl.op  = CELL_HOLD;
        case (r_state)
            S_EXEC: begin
                if (w_free) begin
                    if (r_req == REQ_INSERT && !w_found && !w_full) begin
                        w_ctl.op = CELL_INSERT;
                    end else if (r_req == REQ_DELETE && w_found) begin
                        w_ctl.op = CELL_DELETE;
                    end
                end
            end
            S_LIST: begin
                if (w_free) begin
                    w_ctl.op = (r_req == REQ_LIST_ASC) ? CELL_ROT_LEFT : CELL_ROT_RIGHT;
                end
            end
            default: begin
                w_ctl.op = CELL_HOLD;
            end
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        logic   w_left_ge;
        logic   w_right_valid;

        if (g == 0) begin : g_first
            assign w_left    = w_tail;
            assign w_left_ge = 1'b0;
        end else begin : g_mid_l
            assign w_left    = w_entry[g-1];
            assign w_left_ge = w_ge[g-1];
        end

        if (g == CAPACITY - 1) begin : g_final
            assign w_right       = w_entry[g];
            assign w_right_valid = 1'b0;
        end else begin : g_mid_r
            assign w_right       = w_entry[g+1];
            assign w_right_valid = w_valid[g+1];
        end

        skt_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_cmp_key     (i_key),
            .i_new         (w_new),
            .i_left        (w_left),
            .i_left_ge     (w_left_ge),
            .i_right       (w_right),
            .i_right_valid (w_right_valid),
            .i_head        (w_entry[0]),
            .i_valid       (w_valid[g]),
            .o_entry       (w_entry[g]),
            .o_ge          (w_ge[g]),
            .o_hit         (w_hit[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            // drop the result once it is taken
            if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_req   <= t_req'(i_req_type);
                        r_key   <= i_key;
                        r_name  <= i_name_code;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_free) begin
                        r_o_key  <= r_key;
                        r_o_name <= '0;
                        r_o_last <= 1'b1;
                        case (r_req)
                            REQ_INSERT: begin
                                r_o_valid <= 1'b1;
                                r_state   <= S_IDLE;
                                if (w_found) begin
                                    r_o_status <= ST_DUPLICATE;
                                end else if (w_full) begin
                                    r_o_status <= ST_FULL;
                                end else begin
                                    r_o_status <= ST_INSERTED;
                                    r_count    <= r_count + CW'(1);
                                end
                            end
                            REQ_DELETE: begin
                                r_o_valid <= 1'b1;
                                r_state   <= S_IDLE;
                                if (w_found) begin
                                    r_o_status <= ST_DELETED;
                                    r_count    <= r_count - CW'(1);
                                end else begin
                                    r_o_status <= ST_NOT_FOUND;
                                end
                            end
                            default: begin
                                if (r_count == '0) begin
                                    r_o_valid  <= 1'b1;
                                    r_o_status <= ST_EMPTY;
                                    r_state    <= S_IDLE;
                                end else begin
                                    // hold the slot empty; listing starts next cycle
                                    r_idx   <= '0;
                                    r_state <= S_LIST;
                                end
                            end
                        endcase
                    end
                end
                S_LIST: begin
                    // emit the head or tail, then rotate the chain by one
                    if (w_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_status <= ST_LIST;
                        if (r_req == REQ_LIST_ASC) begin
                            r_o_key  <= w_entry[0].key;
                            r_o_name <= w_entry[0].name;
                        end else begin
                            r_o_key  <= w_tail.key;
                            r_o_name <= w_tail.name;
                        end
                        r_o_last <= w_list_last;
                        r_idx    <= r_idx + CW'(1);
                        if (w_list_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.op == CELL_INSERT) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the count");

    a_delete_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.op == CELL_DELETE) |=> (r_count == $past(r_count) - CW'(1)))
        else $error("delete did not shrink the count");

    a_list_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) |-> (r_idx < r_count))
        else $error("list index past occupied cells");

endmodule
